>>> design/blavg_pkg.sv
// ----------------------------------------------------------------------------
// Baseline averager package
// Shared types and constants for the averager datapath, divider and CSRs.
// ----------------------------------------------------------------------------
package blavg_pkg;

   localparam int BASE_W     = 11;
   localparam int POL_COUNT  = 4;    // polarisations carried per record
   localparam int SQRT_STEPS = 34;   // root bits of a 68-bit radicand
   localparam int DIV_STEPS  = 48;   // quotient bits
   localparam int NUM_LANES  = 12;   // u, v, w, time, 8 visibility parts
   localparam int LANE_U     = 0;
   localparam int LANE_V     = 1;
   localparam int LANE_W     = 2;
   localparam int LANE_TIME  = 3;
   localparam int LANE_VIS0  = 4;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] CSR_MAX_DIST = 2'd0;
   localparam logic [1:0] CSR_MAX_SPAN = 2'd1;
   localparam logic [1:0] CSR_INTERVAL = 2'd2;

   typedef struct packed {
      logic [BASE_W-1:0]  baseline;
      logic signed [31:0] cur_u;
      logic signed [31:0] cur_v;
      logic signed [31:0] cur_w;
      logic [47:0]        cur_time;
      logic [47:0]        step_time;
      logic               last;
      logic [63:0]        vis_a;
      logic [63:0]        vis_b;
   } item_type;

   typedef struct packed {
      logic [39:0]        path;
      logic [47:0]        span;
      logic [15:0]        count;
      logic signed [47:0] sum_u;
      logic signed [47:0] sum_v;
      logic signed [47:0] sum_w;
      logic [63:0]        sum_time;
   } acc_type;

   typedef struct packed {
      logic [BASE_W-1:0]                 baseline;
      logic [15:0]                       count;
      logic [NUM_LANES-1:0][63:0]        value;
      logic [NUM_LANES-1:0]              neg;
   } div_req_type;

   typedef struct packed {
      logic [BASE_W-1:0]                 baseline;
      logic [15:0]                       count;
      logic [NUM_LANES-1:0][DIV_STEPS-1:0] quo;
      logic [NUM_LANES-1:0]              neg;
   } div_rsp_type;

   typedef struct packed {
      logic [BASE_W-1:0]  baseline;
      logic signed [31:0] mean_u;
      logic signed [31:0] mean_v;
      logic signed [31:0] mean_w;
      logic [47:0]        mean_time;
      logic [15:0]        count;
      logic [47:0]        interval;
      logic [63:0]        pair_a;
      logic [63:0]        pair_b;
   } res_type;

endpackage

>>> design/baseline_dependent_averager_unit.sv
// ----------------------------------------------------------------------------
// Baseline dependent averager
// Per-baseline running averages of uvw, time and visibilities, closed by
// path length, time span, count or the last time step.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  req     | in        | req_valid / req_stall  | one visibility record
//  rsp     | out       | rsp_valid / rsp_stall  | one averaged record
//  csr     | in/out    | APB psel/penable/...   | three 32-bit limit registers
//
//  One transaction is taken per cycle while req_stall is low; a record that
//  closes an average passes the input register, squares, 35 root stages,
//  the accumulator read-modify-write, 50 divider stages and the output
//  register.
//  After reset a clearing pass writes zero to every accumulator entry;
//  req_stall stays high meanwhile.
//  An output register and a skid register sit behind the pipeline: input
//  stalls when both hold a result and during the clearing pass.
//
module baseline_dependent_averager_unit #(
   parameter int BASE_COUNT = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   // record channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [blavg_pkg::BASE_W-1:0]      req_baseline,
   input  logic signed [31:0]                req_coord_u,
   input  logic signed [31:0]                req_coord_v,
   input  logic signed [31:0]                req_coord_w,
   input  logic [47:0]                       req_sample_time,
   input  logic signed [31:0]                req_ahead_u,
   input  logic signed [31:0]                req_ahead_v,
   input  logic signed [31:0]                req_ahead_w,
   input  logic [47:0]                       req_ahead_time,
   input  logic                              req_final_step,
   input  logic [63:0]                       req_vis_pair_a,
   input  logic [63:0]                       req_vis_pair_b,
   // average channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [blavg_pkg::BASE_W-1:0]      rsp_out_baseline,
   output logic signed [31:0]                rsp_mean_u,
   output logic signed [31:0]                rsp_mean_v,
   output logic signed [31:0]                rsp_mean_w,
   output logic [47:0]                       rsp_mean_time,
   output logic [15:0]                       rsp_sample_count,
   output logic [47:0]                       rsp_run_interval,
   output logic [63:0]                       rsp_mean_pair_a,
   output logic [63:0]                       rsp_mean_pair_b,
   // register port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [blavg_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import blavg_pkg::*;

   localparam int ADDR_W    = (BASE_COUNT > 1) ? $clog2(BASE_COUNT) : 1;
   localparam int VIS_LANES = 2 * POL_COUNT;
   localparam int VIS_W     = 32 * VIS_LANES;
   localparam int ACC_W     = $bits(acc_type);

   function automatic logic [47:0] apply_sign(input logic [47:0] q, input logic neg);
      apply_sign = neg ? 48'(48'd0 - q) : q;
   endfunction

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   logic [31:0] max_dist_ff, max_span_ff, interval_ff;
   logic        csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_dist_ff <= '0;
         max_span_ff <= '0;
         interval_ff <= '0;
      end else if (csr_wr) begin
         case (paddr[3:2])
            CSR_MAX_DIST: max_dist_ff <= pwdata;
            CSR_MAX_SPAN: max_span_ff <= pwdata;
            CSR_INTERVAL: interval_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         CSR_MAX_DIST: prdata = max_dist_ff;
         CSR_MAX_SPAN: prdata = max_span_ff;
         CSR_INTERVAL: prdata = interval_ff;
         default:      prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Flow control: the whole pipeline advances unless the skid is full
   // ------------------------------------------------------------------
   logic adv;
   logic clr_busy_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic skid_valid_ff, out_valid_ff, out_take;

   assign adv       = !skid_valid_ff;
   assign req_stall = clr_busy_ff || skid_valid_ff;
   assign out_take  = out_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= ADDR_W'(clr_addr_ff + 1'b1);
         if (clr_addr_ff == ADDR_W'(BASE_COUNT - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage A: step deltas. Last step forces both steps to zero.
   // ------------------------------------------------------------------
   logic        a_valid_in, a_valid_ff, in_range;
   item_type    a_item_in, a_item_ff;
   logic [32:0] diff_u, diff_v, diff_w;
   logic [31:0] a_mag_in [3];
   logic [31:0] a_mag_ff [3];

   assign in_range   = 17'(req_baseline) < 17'(BASE_COUNT);
   assign a_valid_in = req_valid && !req_stall && in_range;

   always_comb begin
      diff_u = {req_ahead_u[31], req_ahead_u} - {req_coord_u[31], req_coord_u};
      diff_v = {req_ahead_v[31], req_ahead_v} - {req_coord_v[31], req_coord_v};
      diff_w = {req_ahead_w[31], req_ahead_w} - {req_coord_w[31], req_coord_w};
      a_mag_in[0] = diff_u[32] ? 32'(33'd0 - diff_u) : diff_u[31:0];
      a_mag_in[1] = diff_v[32] ? 32'(33'd0 - diff_v) : diff_v[31:0];
      a_mag_in[2] = diff_w[32] ? 32'(33'd0 - diff_w) : diff_w[31:0];
      a_item_in.baseline  = req_baseline;
      a_item_in.cur_u     = req_coord_u;
      a_item_in.cur_v     = req_coord_v;
      a_item_in.cur_w     = req_coord_w;
      a_item_in.cur_time  = req_sample_time;
      a_item_in.step_time = (req_ahead_time >= req_sample_time)
                            ? 48'(req_ahead_time - req_sample_time) : '0;
      a_item_in.last      = req_final_step;
      a_item_in.vis_a     = req_vis_pair_a;
      a_item_in.vis_b     = req_vis_pair_b;
      if (req_final_step) begin
         a_item_in.step_time = '0;
         for (int i = 0; i < 3; i++) begin
            a_mag_in[i] = '0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage B: squares; stage 0 of the root: sum of squares
   // ------------------------------------------------------------------
   logic        b_valid_ff;
   item_type    b_item_ff;
   logic [63:0] b_sq_ff [3];

   // integer square root, two radicand bits per stage
   logic [SQRT_STEPS:0] sq_valid_ff;
   item_type    sq_item_ff [SQRT_STEPS+1];
   logic [67:0] sq_rad_ff  [SQRT_STEPS+1];
   logic [35:0] sq_rem_ff  [SQRT_STEPS+1];
   logic [33:0] sq_root_ff [SQRT_STEPS+1];
   logic [37:0] sq_t       [SQRT_STEPS+1];
   logic [35:0] sq_trial   [SQRT_STEPS+1];
   logic [SQRT_STEPS:0] sq_ge;
   logic [67:0] sq_rad_in  [SQRT_STEPS+1];
   logic [35:0] sq_rem_in  [SQRT_STEPS+1];
   logic [33:0] sq_root_in [SQRT_STEPS+1];

   always_comb begin
      sq_rad_in[0]  = {2'b00, 66'(b_sq_ff[0]) + 66'(b_sq_ff[1]) + 66'(b_sq_ff[2])};
      sq_rem_in[0]  = '0;
      sq_root_in[0] = '0;
      sq_t[0]       = '0;
      sq_trial[0]   = '0;
      sq_ge[0]      = 1'b0;
      for (int s = 1; s <= SQRT_STEPS; s++) begin
         sq_t[s]     = {sq_rem_ff[s-1], sq_rad_ff[s-1][67:66]};
         sq_trial[s] = {sq_root_ff[s-1], 2'b01};
         sq_ge[s]    = sq_t[s] >= 38'(sq_trial[s]);
         sq_rem_in[s]  = sq_ge[s] ? 36'(sq_t[s] - 38'(sq_trial[s])) : sq_t[s][35:0];
         sq_root_in[s] = {sq_root_ff[s-1][32:0], sq_ge[s]};
         sq_rad_in[s]  = {sq_rad_ff[s-1][65:0], 2'b00};
      end
   end

   // ------------------------------------------------------------------
   // Stage M: accumulator read-modify-write
   // ------------------------------------------------------------------
   logic              m_valid_ff;
   item_type          m_item_ff;
   logic [33:0]       m_dist_ff;
   logic [ADDR_W-1:0] m_addr, rd_addr;
   logic [ACC_W-1:0]  acc_rd_data;
   logic [VIS_W-1:0]  vis_rd_data;
   logic              fwd_valid_ff, fwd_hit;
   logic [ADDR_W-1:0] fwd_addr_ff;
   acc_type           fwd_acc_ff;
   logic [VIS_W-1:0]  fwd_vis_ff;

   acc_type           old_acc, new_acc, acc_wr_data;
   logic [VIS_W-1:0]  old_vis, new_vis, vis_wr_data;
   logic [127:0]      vis_word;
   logic [40:0]       path_sum;
   logic [48:0]       span_sum;
   logic              close;
   div_req_type       div_req;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;

   assign m_addr  = ADDR_W'(m_item_ff.baseline);
   assign rd_addr = ADDR_W'(sq_item_ff[SQRT_STEPS].baseline);
   // the entry written back by the previous M-stage record is not yet in the read data
   assign fwd_hit = fwd_valid_ff && (fwd_addr_ff == m_addr);

   always_comb begin
      old_acc  = fwd_hit ? fwd_acc_ff : acc_type'(acc_rd_data);
      old_vis  = fwd_hit ? fwd_vis_ff : vis_rd_data;
      vis_word = {m_item_ff.vis_b, m_item_ff.vis_a};

      new_acc.count    = 16'(old_acc.count + 16'd1);
      new_acc.sum_u    = 48'(old_acc.sum_u + 48'(m_item_ff.cur_u));
      new_acc.sum_v    = 48'(old_acc.sum_v + 48'(m_item_ff.cur_v));
      new_acc.sum_w    = 48'(old_acc.sum_w + 48'(m_item_ff.cur_w));
      new_acc.sum_time = 64'(old_acc.sum_time + 64'(m_item_ff.cur_time));
      for (int k = 0; k < VIS_LANES; k++) begin
         new_vis[32*k +: 32] = 32'(old_vis[32*k +: 32]
                               + {{16{vis_word[16*k+15]}}, vis_word[16*k +: 16]});
      end

      path_sum = 41'(old_acc.path) + 41'(m_dist_ff);
      span_sum = 49'(old_acc.span) + 49'(m_item_ff.step_time);
      new_acc.path = path_sum[40] ? '1 : path_sum[39:0];
      new_acc.span = span_sum[48] ? '1 : span_sum[47:0];

      close = m_item_ff.last
           || (path_sum > 41'(max_dist_ff))
           || (span_sum > 49'(max_span_ff))
           || (new_acc.count == COUNT_MAX);

      acc_wr_data = close ? '0 : new_acc;
      vis_wr_data = close ? '0 : new_vis;

      div_req.baseline = m_item_ff.baseline;
      div_req.count    = new_acc.count;
      div_req.value    = '0;
      div_req.neg      = '0;
      div_req.value[LANE_U]    = 64'(new_acc.sum_u);
      div_req.neg[LANE_U]      = new_acc.sum_u[47];
      div_req.value[LANE_V]    = 64'(new_acc.sum_v);
      div_req.neg[LANE_V]      = new_acc.sum_v[47];
      div_req.value[LANE_W]    = 64'(new_acc.sum_w);
      div_req.neg[LANE_W]      = new_acc.sum_w[47];
      div_req.value[LANE_TIME] = new_acc.sum_time;
      for (int k = 0; k < VIS_LANES; k++) begin
         div_req.value[LANE_VIS0+k] = {{32{new_vis[32*k+31]}}, new_vis[32*k +: 32]};
         div_req.neg[LANE_VIS0+k]   = new_vis[32*k+31];
      end
   end

   assign ram_wr_en   = clr_busy_ff || (adv && m_valid_ff);
   assign ram_wr_addr = clr_busy_ff ? clr_addr_ff : m_addr;

   blavg_ram #(.WIDTH(ACC_W), .DEPTH(BASE_COUNT)) u_acc_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (clr_busy_ff ? '0 : acc_wr_data),
      .rd_en   (adv),
      .rd_addr (rd_addr),
      .rd_data (acc_rd_data)
   );

   blavg_ram #(.WIDTH(VIS_W), .DEPTH(BASE_COUNT)) u_vis_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (clr_busy_ff ? '0 : vis_wr_data),
      .rd_en   (adv),
      .rd_addr (rd_addr),
      .rd_data (vis_rd_data)
   );

   // ------------------------------------------------------------------
   // Pipeline registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         sq_valid_ff  <= '0;
         m_valid_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= a_valid_ff;
         sq_valid_ff  <= {sq_valid_ff[SQRT_STEPS-1:0], b_valid_ff};
         m_valid_ff   <= sq_valid_ff[SQRT_STEPS];
         fwd_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_item_ff <= a_item_in;
         for (int i = 0; i < 3; i++) begin
            a_mag_ff[i] <= a_mag_in[i];
            b_sq_ff[i]  <= 64'(a_mag_ff[i]) * 64'(a_mag_ff[i]);
         end
         b_item_ff     <= a_item_ff;
         sq_item_ff[0] <= b_item_ff;
         for (int s = 1; s <= SQRT_STEPS; s++) begin
            sq_item_ff[s] <= sq_item_ff[s-1];
         end
         for (int s = 0; s <= SQRT_STEPS; s++) begin
            sq_rad_ff[s]  <= sq_rad_in[s];
            sq_rem_ff[s]  <= sq_rem_in[s];
            sq_root_ff[s] <= sq_root_in[s];
         end
         m_item_ff   <= sq_item_ff[SQRT_STEPS];
         m_dist_ff   <= sq_root_ff[SQRT_STEPS];
         fwd_addr_ff <= m_addr;
         fwd_acc_ff  <= acc_wr_data;
         fwd_vis_ff  <= vis_wr_data;
      end
   end

   // ------------------------------------------------------------------
   // Divider and result formatting
   // ------------------------------------------------------------------
   logic        div_out_valid;
   div_rsp_type div_rsp;
   res_type     res_in, out_ff, skid_ff;
   logic [127:0] mean_vis;
   logic [47:0]  lane_q [NUM_LANES];

   blavg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (m_valid_ff && close),
      .in_data   (div_req),
      .out_valid (div_out_valid),
      .out_data  (div_rsp)
   );

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         lane_q[l] = apply_sign(div_rsp.quo[l], div_rsp.neg[l]);
      end
      for (int k = 0; k < 8; k++) begin
         mean_vis[16*k +: 16] = lane_q[LANE_VIS0+k][15:0];
      end
      res_in.baseline  = div_rsp.baseline;
      res_in.mean_u    = lane_q[LANE_U][31:0];
      res_in.mean_v    = lane_q[LANE_V][31:0];
      res_in.mean_w    = lane_q[LANE_W][31:0];
      res_in.mean_time = lane_q[LANE_TIME];
      res_in.count     = div_rsp.count;
      res_in.interval  = 48'(div_rsp.count) * 48'(interval_ff);
      res_in.pair_a    = mean_vis[63:0];
      res_in.pair_b    = mean_vis[127:64];
   end

   // output register with a skid behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (adv) begin
         if (div_out_valid) begin
            if (!out_valid_ff || out_take) begin
               out_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (out_take) begin
            out_valid_ff <= 1'b0;
         end
      end else if (out_take) begin
         skid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && div_out_valid) begin
         if (!out_valid_ff || out_take) begin
            out_ff <= res_in;
         end else begin
            skid_ff <= res_in;
         end
      end else if (!adv && out_take) begin
         out_ff <= skid_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_baseline = out_ff.baseline;
   assign rsp_mean_u       = out_ff.mean_u;
   assign rsp_mean_v       = out_ff.mean_v;
   assign rsp_mean_w       = out_ff.mean_w;
   assign rsp_mean_time    = out_ff.mean_time;
   assign rsp_sample_count = out_ff.count;
   assign rsp_run_interval = out_ff.interval;
   assign rsp_mean_pair_a  = out_ff.pair_a;
   assign rsp_mean_pair_b  = out_ff.pair_b;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a transaction while the output register is empty");

   a_no_item_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !(m_valid_ff || a_valid_ff || div_out_valid))
      else $error("transaction in flight during the clearing pass");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample_count != 16'd0))
      else $error("average emitted with zero samples");

   a_frozen_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && div_out_valid) |=> div_out_valid)
      else $error("divider result lost while the skid was full");

endmodule

>>> design/blavg_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module blavg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> design/blavg_div.sv
// ----------------------------------------------------------------------------
// Averager divider
// Pipelined restoring divider, one quotient bit per stage over all lanes.
// ----------------------------------------------------------------------------
module blavg_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   in_valid,
   input  blavg_pkg::div_req_type in_data,
   output logic                   out_valid,
   output blavg_pkg::div_rsp_type out_data
);
   import blavg_pkg::*;

   logic                         entry_valid_ff;
   div_req_type                  entry_ff;
   logic [DIV_STEPS:0]           valid_ff;
   logic [BASE_W-1:0]            base_ff  [DIV_STEPS+1];
   logic [15:0]                  count_ff [DIV_STEPS+1];
   logic [NUM_LANES-1:0]         neg_ff   [DIV_STEPS+1];
   logic [15:0]                  rem_ff   [DIV_STEPS+1][NUM_LANES];
   logic [DIV_STEPS-1:0]         quo_ff   [DIV_STEPS+1][NUM_LANES];
   logic [15:0]                  rem_in   [DIV_STEPS+1][NUM_LANES];
   logic [DIV_STEPS-1:0]         quo_in   [DIV_STEPS+1][NUM_LANES];
   logic [63:0]                  mag      [NUM_LANES];
   logic [16:0]                  trial    [DIV_STEPS+1][NUM_LANES];
   logic [DIV_STEPS:0][NUM_LANES-1:0] ge;

   // first stage: magnitudes; dividend top bits are always below the count
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         mag[l] = entry_ff.neg[l] ? 64'(64'd0 - entry_ff.value[l]) : entry_ff.value[l];
         rem_in[0][l] = mag[l][63:DIV_STEPS];
         quo_in[0][l] = mag[l][DIV_STEPS-1:0];
         trial[0][l]  = '0;
         ge[0][l]     = 1'b0;
      end
      for (int s = 1; s <= DIV_STEPS; s++) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            trial[s][l] = {rem_ff[s-1][l], quo_ff[s-1][l][DIV_STEPS-1]};
            ge[s][l]    = trial[s][l] >= {1'b0, count_ff[s-1]};
            rem_in[s][l] = ge[s][l] ? 16'(trial[s][l] - {1'b0, count_ff[s-1]})
                                    : trial[s][l][15:0];
            quo_in[s][l] = {quo_ff[s-1][l][DIV_STEPS-2:0], ge[s][l]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
         valid_ff       <= '0;
      end else if (enable) begin
         entry_valid_ff <= in_valid;
         valid_ff       <= {valid_ff[DIV_STEPS-1:0], entry_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         entry_ff    <= in_data;
         base_ff[0]  <= entry_ff.baseline;
         count_ff[0] <= entry_ff.count;
         neg_ff[0]   <= entry_ff.neg;
         for (int s = 1; s <= DIV_STEPS; s++) begin
            base_ff[s]  <= base_ff[s-1];
            count_ff[s] <= count_ff[s-1];
            neg_ff[s]   <= neg_ff[s-1];
         end
         for (int s = 0; s <= DIV_STEPS; s++) begin
            for (int l = 0; l < NUM_LANES; l++) begin
               rem_ff[s][l] <= rem_in[s][l];
               quo_ff[s][l] <= quo_in[s][l];
            end
         end
      end
   end

   always_comb begin
      out_valid         = valid_ff[DIV_STEPS];
      out_data.baseline = base_ff[DIV_STEPS];
      out_data.count    = count_ff[DIV_STEPS];
      out_data.neg      = neg_ff[DIV_STEPS];
      for (int l = 0; l < NUM_LANES; l++) begin
         out_data.quo[l] = quo_ff[DIV_STEPS][l];
      end
   end

endmodule
